[rtl/core/sliding_window_peak_counter_macros.svh]
// Assertion macros used by the peak counter RTL.
`ifndef SLIDING_WINDOW_PEAK_COUNTER_MACROS_SVH
`define SLIDING_WINDOW_PEAK_COUNTER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while in reset.
`define SWPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off while in reset.
`define SWPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWPC_ASSERT_IMP(lbl, ante, cons, msg)
`define SWPC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/swpc_pkg.sv]
// Constants and types of the sliding window peak counter.
package swpc_pkg;

    localparam int WINDOW_MAX = 1024;
    localparam int SAMPLE_W   = 32;
    localparam int MAX_LENGTH = 1048576;

    localparam int ADDR_W  = $clog2(WINDOW_MAX);
    localparam int POS_W   = $clog2(MAX_LENGTH) + 1;
    localparam int LEFT_W  = $clog2(MAX_LENGTH);
    localparam int CNT_W   = 10;
    localparam int LEN_W   = 11;
    localparam int SCORE_W = 10;
    localparam int START_W = 21;
    localparam int LEN_MIN = 3;

    // Write request into the flag memory
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              data;
    } flag_wr_t;

    // Read request into the flag memory
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } flag_rd_t;

endpackage

[rtl/core/swpc_if.sv]
// Channel interfaces: sample input, result output and length write.
interface swpc_in_if import swpc_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface swpc_out_if import swpc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] best_score;
    logic [START_W-1:0] best_start;
    logic               too_short;

    modport source (output valid, output best_score, output best_start, output too_short,
                    input ready);
    modport sink   (input valid, input best_score, input best_start, input too_short,
                    output ready);
endinterface

interface swpc_cfg_if import swpc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

[rtl/core/swpc_flag_ram.sv]
// Peak flag delay line: one-bit RAM, one write and one registered read port.
module swpc_flag_ram import swpc_pkg::*;
(
    input  logic     clk,
    input  flag_wr_t wr,
    input  flag_rd_t rd,
    output logic     rd_data
);

    logic mem [WINDOW_MAX];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port, data held while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

[rtl/core/sliding_window_peak_counter.sv]
// Top level of the sliding window peak counter.
// Takes one sample item per clock cycle unless stalled. A sample is marked as a peak
// once its right neighbor arrives; peak flags go into a 1024-entry flag RAM that acts
// as the window's delay line, and a running count adds the new flag and drops the flag
// leaving the window. The pipeline has two stages: stage 0 accepts the item, detects the
// peak, writes its flag and reads the outgoing flag; stage 1 takes the registered RAM
// read data and updates the running count and the best window. The result for the
// item marked last passes from the stage 1 register into the output register, where it
// waits until taken. The input keeps taking items while a result waits, until the next
// item marked last reaches stage 1 with the output still full; it then stalls until
// the output is taken. After reset the flag RAM is cleared, one entry per cycle; no
// sample item is accepted then, while length writes are. Length writes are meant for
// when the block is idle.
`include "sliding_window_peak_counter_macros.svh"

module sliding_window_peak_counter import swpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    swpc_in_if.sink    samples,
    swpc_out_if.source result,
    swpc_cfg_if.sink   cfg
);

    // Configuration
    logic [LEN_W-1:0] window_length_reg;

    // Flag RAM clearing after reset
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // Stage 0 state
    logic signed [SAMPLE_W-1:0] older_reg;
    logic signed [SAMPLE_W-1:0] newer_reg;
    logic [POS_W-1:0]           position_reg;

    // Stage 1 pipeline register
    logic              s1_valid_reg;
    logic              s1_last_reg;
    logic              s1_active_reg;
    logic              s1_sub_en_reg;
    logic              s1_add_reg;
    logic              s1_first_reg;
    logic [LEFT_W-1:0] s1_left_reg;
    logic              s1_short_reg;

    // Sequence counters
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  best_count_reg;
    logic [LEFT_W-1:0] best_left_reg;

    // Output register
    logic               out_valid_reg;
    logic [SCORE_W-1:0] out_score_reg;
    logic [START_W-1:0] out_start_reg;
    logic               out_short_reg;

    logic             in_acc;
    logic             s1_go;
    logic [LEN_W-1:0] k_eff;
    logic [POS_W-1:0] k_ext;
    logic [POS_W-1:0] e;
    logic [POS_W-1:0] diff;
    logic [POS_W-1:0] pos_after;
    logic             active;
    logic             ge_k;
    logic             ge_two;
    logic             flag;
    flag_wr_t         ram_wr;
    flag_rd_t         ram_rd;
    logic             ram_rd_data;

    logic [CNT_W-1:0]  cnt_new;
    logic [CNT_W-1:0]  best_fin;
    logic [LEFT_W-1:0] left_fin;
    logic              load_out;

    // Effective window length, clamped to the legal range
    always_comb
    begin
        if (window_length_reg < LEN_W'(LEN_MIN))
        begin
            k_eff = LEN_W'(LEN_MIN);
        end
        else if (window_length_reg > LEN_W'(WINDOW_MAX))
        begin
            k_eff = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            k_eff = window_length_reg;
        end
    end

    // Handshakes: stage 1 only waits when it holds a result and the output is full
    assign s1_go         = !(s1_last_reg && out_valid_reg && !result.ready);
    assign samples.ready = !clearing_reg && (!s1_valid_reg || s1_go);
    assign in_acc        = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;

    // Stage 0 decode
    assign e         = position_reg;
    assign k_ext     = POS_W'(k_eff);
    assign diff      = e - k_ext + POS_W'(1);
    assign active    = e < POS_W'(MAX_LENGTH);
    assign ge_k      = e >= k_ext;
    assign ge_two    = e >= POS_W'(2);
    assign flag      = (older_reg < newer_reg) && (newer_reg > samples.sample);
    assign pos_after = active ? e + POS_W'(1) : e;

    // Flag RAM ports; clearing pass owns the write port after reset.
    // The read index trails the write index by at least one, so no forwarding.
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = clr_addr_reg;
            ram_wr.data = 1'b0;
        end
        else
        begin
            ram_wr.en   = in_acc && active && ge_two;
            ram_wr.addr = ADDR_W'(e - POS_W'(1));
            ram_wr.data = flag;
        end
        ram_rd.en   = in_acc && active && ge_k;
        ram_rd.addr = diff[ADDR_W-1:0];
    end

    swpc_flag_ram u_flag_ram
    (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_rd_data)
    );

    // Length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= LEN_W'(LEN_MIN);
        end
        else if (cfg.valid)
        begin
            window_length_reg <= cfg.window_length;
        end
    end

    // Clearing pass over the flag RAM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(WINDOW_MAX - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Stage 0: sample history and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
        end
        else if (in_acc)
        begin
            position_reg <= samples.last_sample ? '0 : pos_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && active)
        begin
            older_reg <= newer_reg;
            newer_reg <= samples.sample;
        end
    end

    // Stage 1 pipeline register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
            s1_last_reg  <= samples.last_sample;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_active_reg <= active;
            s1_sub_en_reg <= ge_k;
            s1_add_reg    <= ge_two && flag;
            s1_first_reg  <= (e + POS_W'(1)) == k_ext;
            s1_left_reg   <= diff[LEFT_W-1:0];
            s1_short_reg  <= pos_after < k_ext;
        end
    end

    // Stage 1: running count and best window
    always_comb
    begin
        cnt_new  = count_reg - CNT_W'(s1_sub_en_reg && ram_rd_data) + CNT_W'(s1_add_reg);
        best_fin = best_count_reg;
        left_fin = best_left_reg;
        if (s1_active_reg)
        begin
            if (s1_first_reg)
            begin
                best_fin = cnt_new;
                left_fin = '0;
            end
            else if (s1_sub_en_reg && (cnt_new > best_count_reg))
            begin
                best_fin = cnt_new;
                left_fin = s1_left_reg;
            end
        end
    end

    assign load_out = s1_valid_reg && s1_last_reg && s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            best_count_reg <= '0;
            best_left_reg  <= '0;
        end
        else if (s1_valid_reg && s1_go)
        begin
            if (s1_last_reg)
            begin
                count_reg      <= '0;
                best_count_reg <= '0;
                best_left_reg  <= '0;
            end
            else if (s1_active_reg)
            begin
                count_reg      <= cnt_new;
                best_count_reg <= best_fin;
                best_left_reg  <= left_fin;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (s1_short_reg)
            begin
                out_score_reg <= '0;
                out_start_reg <= '0;
                out_short_reg <= 1'b1;
            end
            else
            begin
                out_score_reg <= SCORE_W'(best_fin + CNT_W'(1));
                out_start_reg <= START_W'(left_fin) + START_W'(1);
                out_short_reg <= 1'b0;
            end
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.best_score = out_score_reg;
    assign result.best_start = out_start_reg;
    assign result.too_short  = out_short_reg;

    // Checks
    `SWPC_ASSERT_IMP(a_clear_empty, clearing_reg, !s1_valid_reg && !out_valid_reg,
        "pipeline busy during flag clearing")
    `SWPC_ASSERT_IMP(a_out_source, $rose(out_valid_reg), $past(s1_valid_reg && s1_last_reg),
        "result without a last item in stage 1")
    `SWPC_ASSERT_IMP(a_short_zero, out_valid_reg && out_short_reg,
        out_score_reg == '0 && out_start_reg == '0, "short result carries nonzero fields")
    `SWPC_ASSERT_IMP(a_ram_addr, ram_rd.en && ram_wr.en, ram_rd.addr != ram_wr.addr,
        "flag read and write hit the same entry")
    `SWPC_ASSERT_NXT(a_last_clears, in_acc && samples.last_sample, position_reg == '0,
        "position not cleared after last item")

endmodule
